// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the RTL in this folder; the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising edge once out of reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition seen at one edge leads to a consequence at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

// ===== rtl/core/cbt_pkg.sv =====
// Package: constants shared by the CAN bit timing calculator.
package cbt_pkg;

    localparam int OSC_W         = 32;
    localparam int DIV_W         = 20;
    localparam int STEP_W        = $clog2(OSC_W);
    localparam int M_W           = 13;
    localparam int MAX_PRESCALER = 256;
    localparam int BRP_W         = $clog2(MAX_PRESCALER + 1);
    localparam int PROD_W        = BRP_W + 7;
    localparam int CMP_W         = (PROD_W > M_W) ? PROD_W : M_W;

    localparam logic [DIV_W-1:0] BIT_RATE_HZ = DIV_W'(1000000);
    localparam logic [OSC_W-1:0] MIN_OSC_HZ  = OSC_W'(8000000);
    localparam logic [M_W-1:0]   MIN_TQ      = M_W'(8);
    localparam logic [M_W-1:0]   MAX_TQ      = M_W'(80);
    localparam logic [4:0]       TSEG2_MIN   = 5'd2;
    localparam logic [4:0]       SJW_MAX     = 5'd16;
    localparam logic [7:0]       RECIP_5     = 8'd205;

endpackage

// ===== rtl/core/can_bit_timing_1mbps_calc_unit.sv =====
// Top level: CAN 1 Mbit/s nominal bit timing calculator with a shared divider.
// Sequence: osc_hz / 1e6 on the divider, then one division per prescaler trial (up to 255),
//   then a final step in S_DONE that raises done.
// Flow: one transaction at a time; busy drops with the done strobe, so the next
//   transaction is taken after the last one ends; each division uses the 32-step divider.
// Reset: rst_n is asynchronous, active low; it returns the sequencer to idle and drops done.
// The result is shown for one cycle with done high; the receiver cannot stall it.
module can_bit_timing_1mbps_calc_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [cbt_pkg::OSC_W-1:0] osc_hz,
    output logic                      done,
    output logic                      ok,
    output logic [31:0]               timing_word,
    output logic [6:0]                quanta_per_bit
);
    import cbt_pkg::*;

`include "assert_macros.svh"

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV1 = 5'b00010,
        S_TEST = 5'b00100,
        S_DIV2 = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [OSC_W-1:0]  osc_reg, osc_next;
    logic [M_W-1:0]    m_reg, m_next;       // osc_hz / 1e6
    logic [M_W-1:0]    tq_reg, tq_next;     // quanta per bit under trial
    logic [BRP_W-1:0]  brp_reg, brp_next;
    logic              exact_reg, exact_next;
    logic              done_reg, done_next;
    logic              ok_reg, ok_next;
    logic [31:0]       word_reg, word_next;
    logic [6:0]        qpb_reg, qpb_next;

    // Divider request.
    logic              div_start;
    logic [OSC_W-1:0]  div_dividend;
    logic [DIV_W-1:0]  div_divisor;
    logic              div_done;
    logic [OSC_W-1:0]  div_quot;
    logic [DIV_W-1:0]  div_rem;

    // Segment arithmetic for the final step.
    logic [6:0]        tq7;
    logic [14:0]       tq_x205;
    logic [4:0]        tseg2_raw, tseg2, sjw;
    logic [6:0]        tseg1;
    logic [CMP_W-1:0]  brp_tq;
    logic [BRP_W-1:0]  brp_m1;
    logic              legal;

    cbt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    // tq / 5 by reciprocal: exact for every tq below 128, the range of tq7.
    assign tq7       = tq_reg[6:0];
    assign tq_x205   = 15'(tq7) * 15'(RECIP_5);
    assign tseg2_raw = tq_x205[14:10];
    assign tseg2     = (tseg2_raw < TSEG2_MIN) ? TSEG2_MIN : tseg2_raw;
    assign tseg1     = tq7 - 7'(tseg2) - 7'd1;
    assign sjw       = (tseg2 > SJW_MAX) ? SJW_MAX : tseg2;
    assign brp_tq    = CMP_W'(brp_reg) * CMP_W'(tq7);
    assign brp_m1    = brp_reg - 1'b1;

    // Legal only for an exact split of each microsecond into brp * tq oscillator periods.
    assign legal = exact_reg && (osc_reg >= MIN_OSC_HZ)
                && (tq_reg >= MIN_TQ) && (tq_reg <= MAX_TQ)
                && (brp_tq == CMP_W'(m_reg));

    always_comb
    begin
        state_next   = state_reg;
        osc_next     = osc_reg;
        m_next       = m_reg;
        tq_next      = tq_reg;
        brp_next     = brp_reg;
        exact_next   = exact_reg;
        done_next    = 1'b0;
        ok_next      = ok_reg;
        word_next    = word_reg;
        qpb_next     = qpb_reg;
        div_start    = 1'b0;
        div_dividend = osc_reg;
        div_divisor  = BIT_RATE_HZ;

        case (state_reg)
            S_IDLE:
            begin
                // Accept a transaction and launch osc_hz / 1e6.
                if (start)
                begin
                    osc_next     = osc_hz;
                    div_start    = 1'b1;
                    div_dividend = osc_hz;
                    state_next   = S_DIV1;
                end
            end
            S_DIV1:
            begin
                if (div_done)
                begin
                    m_next     = div_quot[M_W-1:0];
                    tq_next    = div_quot[M_W-1:0];
                    exact_next = (div_rem == '0);
                    brp_next   = BRP_W'(1);
                    state_next = S_TEST;
                end
            end
            S_TEST:
            begin
                // A non-zero remainder by 1e6 rules out every prescaler: finish at once.
                if (exact_reg && (tq_reg > MAX_TQ) && (brp_reg < BRP_W'(MAX_PRESCALER)))
                begin
                    brp_next     = brp_reg + 1'b1;
                    div_start    = 1'b1;
                    div_dividend = OSC_W'(m_reg);
                    div_divisor  = DIV_W'(brp_reg + 1'b1);
                    state_next   = S_DIV2;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DIV2:
            begin
                // Take the new quanta only where this prescaler divides exactly.
                if (div_done)
                begin
                    if (div_rem == '0)
                    begin
                        tq_next = div_quot[M_W-1:0];
                    end
                    state_next = S_TEST;
                end
            end
            S_DONE:
            begin
                done_next = 1'b1;
                ok_next   = legal;
                if (legal)
                begin
                    word_next = (32'(brp_m1) << 24)
                              | {8'd0, 8'(tseg1 - 7'd1), 16'd0}
                              | {16'd0, 8'(tseg2 - 5'd1), 8'd0}
                              | {24'd0, 8'(sjw - 5'd1)};
                    qpb_next  = tq7;
                end
                else
                begin
                    word_next = '0;
                    qpb_next  = '0;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Hold payload; no reset needed.
    always_ff @(posedge clk)
    begin
        osc_reg   <= osc_next;
        m_reg     <= m_next;
        tq_reg    <= tq_next;
        brp_reg   <= brp_next;
        exact_reg <= exact_next;
        ok_reg    <= ok_next;
        word_reg  <= word_next;
        qpb_reg   <= qpb_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign ok             = ok_reg;
    assign timing_word    = word_reg;
    assign quanta_per_bit = qpb_reg;

    // A result is only shown once the sequencer is back in idle.
    `ASSERT_CLK(a_done_not_busy, clk, rst_n, !(done && busy),
        "result strobe while busy")
    // An accepted transaction makes the block busy on the next cycle.
    `ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy,
        "accepted transaction did not raise busy")
    // A good result carries quanta within the legal range.
    `ASSERT_CLK(a_ok_range, clk, rst_n,
        !(done && ok) || ((quanta_per_bit >= 7'd8) && (quanta_per_bit <= 7'd80)),
        "ok result with quanta out of range")
    // A failed result carries zero payload.
    `ASSERT_CLK(a_fail_zero, clk, rst_n,
        !(done && !ok) || ((timing_word == 32'd0) && (quanta_per_bit == 7'd0)),
        "failed result with non-zero payload")

endmodule

// ===== rtl/core/cbt_div.sv =====
// Shared restoring divider: one quotient bit per cycle over the full dividend width.
module cbt_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [cbt_pkg::OSC_W-1:0] dividend,
    input  logic [cbt_pkg::DIV_W-1:0] divisor,
    output logic                      done,
    output logic [cbt_pkg::OSC_W-1:0] quot,
    output logic [cbt_pkg::DIV_W-1:0] rem
);
    import cbt_pkg::*;

    logic [OSC_W-1:0]  quot_reg, quot_next;
    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  dsr_reg, dsr_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [DIV_W:0]    partial;
    logic [DIV_W:0]    diff;

    assign partial = {rem_reg, quot_reg[OSC_W-1]};
    assign diff    = partial - {1'b0, dsr_reg};

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            quot_next = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = '0;
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            // Shift in the next dividend bit and subtract where it fits.
            if (!diff[DIV_W])
            begin
                rem_next  = diff[DIV_W-1:0];
                quot_next = {quot_reg[OSC_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = partial[DIV_W-1:0];
                quot_next = {quot_reg[OSC_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == STEP_W'(OSC_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

// ===== verif/tb_can_bit_timing_1mbps_calc_unit.sv =====
// Testbench for the CAN 1 Mbit/s nominal bit timing calculator: directed table plus random oscillators.
module tb_can_bit_timing_1mbps_calc_unit;
    timeunit 1ns;
    timeprecision 1ps;

    // Arithmetic constants of the timing search.
    localparam longint unsigned BIT_RATE  = 64'd1_000_000;
    localparam longint unsigned OSC_FLOOR = 64'd8_000_000;
    localparam longint unsigned TQ_LO     = 64'd8;
    localparam longint unsigned TQ_HI     = 64'd80;
    localparam longint unsigned SEG2_DIV  = 64'd5;
    localparam longint unsigned SEG2_LO   = 64'd2;
    localparam longint unsigned SJW_CAP   = 64'd16;
    localparam longint unsigned SEG1_LO   = 64'd2;
    localparam longint unsigned SEG1_HI   = 64'd256;
    localparam longint unsigned BRP_CAP   = longint'(cbt_pkg::MAX_PRESCALER);

    localparam int RANDOM_ITEMS  = 80;
    // The tail of the random part runs with no sender gaps at all.
    localparam int GAPLESS_TAIL  = 20;
    // Quiet cycles after the last result, well beyond the shortest latency.
    localparam int SETTLE_CYCLES = 100;

    // One result of the block, as the predictor sees it.
    typedef struct packed {
        logic        ok;
        logic [31:0] word;
        logic [6:0]  tq;
    } timing_t;

    // One row of the directed table; a row with has_fixed set carries its
    // expected result typed in, the others go through the predictor.
    typedef struct packed {
        logic [31:0] osc;
        logic        has_fixed;
        timing_t     fixed;
    } dir_row_t;

    localparam timing_t REJECT = '{ok: 1'b0, word: 32'h0, tq: 7'd0};

    localparam int DIR_ROWS = 21;
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // Zero and slow oscillators are rejected outright.
        '{32'd0,             1'b1, REJECT},
        '{32'd1_000_000,     1'b0, REJECT},
        '{32'd7_999_999,     1'b1, REJECT},
        // Lowest legal oscillator: eight quanta, phase2 held at its minimum.
        '{32'd8_000_000,     1'b1, '{1'b1, 32'h0004_0101, 7'd8}},
        '{32'd10_000_000,    1'b1, '{1'b1, 32'h0006_0101, 7'd10}},
        // Inexact division with no prescaler search.
        '{32'd8_000_001,     1'b1, REJECT},
        '{32'd79_999_999,    1'b0, REJECT},
        // Exact rates inside the range, no search either.
        '{32'd12_000_000,    1'b0, REJECT},
        '{32'd25_000_000,    1'b0, REJECT},
        // Eighty quanta: the widest phase2 and the capped jump width.
        '{32'd80_000_000,    1'b1, '{1'b1, 32'h003E_0F0F, 7'd80}},
        // Search needed: the prescaler steps until the quanta fit.
        '{32'd81_000_000,    1'b0, REJECT},
        '{32'd96_000_000,    1'b0, REJECT},
        '{32'd99_000_000,    1'b0, REJECT},
        '{32'd160_000_000,   1'b0, REJECT},
        // Quanta fall below eight once a divisor is found.
        '{32'd83_000_000,    1'b0, REJECT},
        // No divisor up to the prescaler cap: inexact at the end.
        '{32'd257_000_000,   1'b0, REJECT},
        // Large oscillators with wide prescaler searches; the last one is inexact and rejected.
        '{32'd2_008_000_000, 1'b0, REJECT},
        '{32'd2_048_000_000, 1'b0, REJECT},
        '{32'd4_000_000_000, 1'b0, REJECT},
        '{32'd3_999_999_999, 1'b0, REJECT},
        // All ones: the division by the bit rate is inexact, so it is rejected.
        '{32'hFFFF_FFFF,     1'b1, REJECT}
    };

    logic        clk;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [31:0] osc_hz = 32'h0;
    logic        busy;
    logic        done;
    logic        ok;
    logic [31:0] timing_word;
    logic [6:0]  quanta_per_bit;

    // Expected timings in the order the transactions were accepted.
    timing_t pending_timings [$];

    int mismatches   = 0;
    int sent_count   = 0;
    int legal_count  = 0;
    int reject_count = 0;

    can_bit_timing_1mbps_calc_unit DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .osc_hz         (osc_hz),
        .done           (done),
        .ok             (ok),
        .timing_word    (timing_word),
        .quanta_per_bit (quanta_per_bit)
    );

    // 4 ns clock, first rising edge at 2 ns.
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Derive the 1 Mbit/s timing for one oscillator frequency.
    function automatic timing_t derive_bit_timing(input logic [31:0] f);
        longint unsigned osc;
        longint unsigned brp;
        longint unsigned tq;
        longint unsigned divisor;
        longint unsigned seg1;
        longint unsigned seg2;
        longint unsigned sjw;
        longint unsigned packed_word;
        timing_t         res;
        osc = longint'(f);
        brp = 1;
        res = REJECT;
        if (osc < OSC_FLOOR)
        begin
            return res;
        end
        tq = osc / BIT_RATE;
        // Step the prescaler; take new quanta only on an exact division.
        while (tq > TQ_HI && brp < BRP_CAP)
        begin
            brp++;
            divisor = BIT_RATE * brp;
            if (osc % divisor == 0)
            begin
                tq = osc / divisor;
            end
        end
        if (osc != BIT_RATE * brp * tq || tq < TQ_LO || tq > TQ_HI)
        begin
            return res;
        end
        // 80 percent sample point.
        seg2 = tq / SEG2_DIV;
        if (seg2 < SEG2_LO)
        begin
            seg2 = SEG2_LO;
        end
        seg1 = tq - seg2 - 1;
        sjw  = (seg2 > SJW_CAP) ? SJW_CAP : seg2;
        if (seg1 < SEG1_LO || seg1 > SEG1_HI)
        begin
            return res;
        end
        // Bits of a wide prescaler above bit 31 are dropped.
        packed_word = ((brp - 1) << 24) | ((seg1 - 1) << 16) | ((seg2 - 1) << 8) | (sjw - 1);
        res.ok   = 1'b1;
        res.word = packed_word[31:0];
        res.tq   = tq[6:0];
        return res;
    endfunction

    // Pick a random oscillator: mostly exact multiples of the bit rate with
    // small prescalers, plus slow clocks, near misses and raw 32-bit noise.
    function automatic logic [31:0] next_osc();
        int unsigned     pick;
        int unsigned     brp_pick;
        longint unsigned brp;
        longint unsigned tq;
        longint unsigned f;
        pick = $urandom_range(0, 99);
        if (pick < 65)
        begin
            brp_pick = $urandom_range(0, 99);
            if (brp_pick < 80)
                brp = $urandom_range(1, 8);
            else if (brp_pick < 95)
                brp = $urandom_range(9, 40);
            else
                brp = $urandom_range(41, cbt_pkg::MAX_PRESCALER);
            tq = ($urandom_range(0, 99) < 85) ? $urandom_range(8, 80) : $urandom_range(1, 120);
            f = BIT_RATE * brp * tq;
            // Hold the product inside 32 bits.
            if (f > 64'hFFFF_FFFF)
            begin
                f = BIT_RATE * brp * $urandom_range(8, 16);
            end
            return f[31:0];
        end
        else if (pick < 75)
        begin
            return $urandom_range(0, 7_999_999);
        end
        else if (pick < 85)
        begin
            // Off by a little from an exact rate; kept below the search.
            f = BIT_RATE * $urandom_range(8, 80);
            if ($urandom_range(0, 1) == 1)
                f = f + $urandom_range(1, 1000);
            else
                f = f - $urandom_range(1, 1000);
            return f[31:0];
        end
        return $urandom();
    endfunction

    // Present one frequency and hold it until the block takes it.
    task automatic issue_osc(input logic [31:0] f, input timing_t expected);
        start  <= 1'b1;
        osc_hz <= f;
        do
            @(posedge clk);
        while (busy);
        pending_timings.push_back(expected);
        sent_count++;
    endtask

    // Drop start for a burst of idle cycles.
    task automatic hold_off(input int cycles);
        start <= 1'b0;
        osc_hz <= $urandom();
        repeat (cycles) @(posedge clk);
    endtask

    // Check each strobed result against the oldest expectation.
    always @(posedge clk)
    begin
        timing_t want;
        if (rst_n && done)
        begin
            if (pending_timings.size() == 0)
            begin
                $error("unexpected result: ok %0d, timing_word %h, quanta_per_bit %0d",
                       ok, timing_word, quanta_per_bit);
                mismatches++;
            end
            else
            begin
                want = pending_timings.pop_front();
                if (ok !== want.ok)
                begin
                    $error("ok: expected %0d, got %0d", want.ok, ok);
                    mismatches++;
                end
                if (timing_word !== want.word)
                begin
                    $error("timing_word: expected %h, got %h", want.word, timing_word);
                    mismatches++;
                end
                if (quanta_per_bit !== want.tq)
                begin
                    $error("quanta_per_bit: expected %0d, got %0d", want.tq, quanta_per_bit);
                    mismatches++;
                end
                if (ok === 1'b1)
                    legal_count++;
                else
                    reject_count++;
            end
        end
    end

    initial
    begin
        logic [31:0] f;
        // Hold reset low at the start, then release it on an edge.
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table with the odd gap between rows.
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if ($urandom_range(0, 2) == 0)
                hold_off($urandom_range(1, 6));
            if (DIRECTED[i].has_fixed)
                issue_osc(DIRECTED[i].osc, DIRECTED[i].fixed);
            else
                issue_osc(DIRECTED[i].osc, derive_bit_timing(DIRECTED[i].osc));
        end

        // Pause the sender until every directed result is back.
        start <= 1'b0;
        while (pending_timings.size() != 0)
            @(posedge clk);

        // Random part; the tail runs back to back.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i < RANDOM_ITEMS - GAPLESS_TAIL && $urandom_range(0, 2) == 0)
                hold_off($urandom_range(1, 6));
            f = next_osc();
            issue_osc(f, derive_bit_timing(f));
        end
        start <= 1'b0;

        // Drain, then watch a while longer for stray strobes.
        while (pending_timings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d transactions (%0d directed rows): %0d legal timings, %0d rejected.",
                 sent_count, DIR_ROWS, legal_count, reject_count);
        $display("Covered slow, inexact, out-of-range and searched oscillators up to 32'hFFFFFFFF.");
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Slowest correct run is about 101 transactions, each with a full prescaler
    // search, some 3.5 ms in all; allow several times that.
    initial
    begin
        #25_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
